/* design/spa_pkg.sv */
package spa_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int MAX_SLOTS    = 32;
    localparam int HEADER_BYTES = 8;

    // field widths
    localparam int OFF_W   = 13;
    localparam int SIZE_W  = 12;
    localparam int SLOTF_W = 6;
    localparam int OP_W    = 3;
    localparam int KIND_W  = 2;

    // directory addressing
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int ENTRY_W = OFF_W + SIZE_W;

    localparam int FRAG_LIMIT = PAGE_BYTES / 4;
    localparam int FRAG_MAX   = (1 << OFF_W) - 1;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_GET    = 3'd3,
        OP_DEFRAG = 3'd4
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_GET   = 2'd2,
        KIND_MOVE  = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_DISPATCH,
        CMD_RP_SKIP,
        CMD_RP_READ,
        CMD_RP_MOVE,
        CMD_RP_END,
        CMD_SPACE,
        CMD_ALLOC,
        CMD_FINAL
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            frag_high;
        logic            rp_done;
        logic            rp_live;
        logic            out_free;
    } t_status;

endpackage

/* design/spa_ram.sv */
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/spa_ctrl.sv */
module spa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  spa_pkg::t_status   i_status,
    output spa_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_RP_SCAN  = 7'b0000100,
        S_RP_MOVE  = 7'b0001000,
        S_SPACE    = 7'b0010000,
        S_ALLOC    = 7'b0100000,
        S_FINAL    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = spa_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = spa_pkg::CMD_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd = spa_pkg::CMD_DISPATCH;
                if (i_status.op == spa_pkg::OP_DEFRAG) begin
                    n_state = S_RP_SCAN;
                end else if (i_status.op == spa_pkg::OP_ALLOC) begin
                    n_state = i_status.frag_high ? S_RP_SCAN : S_SPACE;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_RP_SCAN: begin
                if (i_status.rp_done) begin
                    o_cmd   = spa_pkg::CMD_RP_END;
                    n_state = (i_status.op == spa_pkg::OP_ALLOC) ? S_SPACE : S_FINAL;
                end else if (i_status.rp_live) begin
                    o_cmd   = spa_pkg::CMD_RP_READ;
                    n_state = S_RP_MOVE;
                end else begin
                    o_cmd = spa_pkg::CMD_RP_SKIP;
                end
            end
            S_RP_MOVE: begin
                if (i_status.out_free) begin
                    o_cmd   = spa_pkg::CMD_RP_MOVE;
                    n_state = S_RP_SCAN;
                end
            end
            S_SPACE: begin
                o_cmd   = spa_pkg::CMD_SPACE;
                n_state = S_ALLOC;
            end
            S_ALLOC: begin
                if (i_status.out_free) begin
                    o_cmd   = spa_pkg::CMD_ALLOC;
                    n_state = S_IDLE;
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd   = spa_pkg::CMD_FINAL;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* design/spa_dp.sv */
module spa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spa_pkg::t_cmd                     i_cmd,
    output spa_pkg::t_status                  o_status,
    input  logic [spa_pkg::OP_W-1:0]          i_opcode,
    input  logic [spa_pkg::SIZE_W-1:0]        i_alloc_size,
    input  logic [spa_pkg::SLOTF_W-1:0]       i_slot_index,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic [spa_pkg::KIND_W-1:0]        o_result_kind,
    output logic [spa_pkg::SLOTF_W-1:0]       o_slot_number,
    output logic [spa_pkg::OFF_W-1:0]         o_cell_offset,
    output logic [spa_pkg::OFF_W-1:0]         o_source_offset,
    output logic [spa_pkg::OFF_W-1:0]         o_move_length,
    output logic [spa_pkg::SIZE_W-1:0]        o_cell_size,
    output logic                              o_ok,
    output logic                              o_last
);

    localparam int SW = spa_pkg::SLOT_W;
    localparam int CW = spa_pkg::CNT_W;
    localparam int OW = spa_pkg::OFF_W;
    localparam int ZW = spa_pkg::SIZE_W;

    // directory state
    logic [spa_pkg::MAX_SLOTS-1:0] r_valid;
    logic [CW-1:0]                 r_siu;
    logic [OW-1:0]                 r_frag;
    logic [OW-1:0]                 r_free_top;

    // current item
    logic [spa_pkg::OP_W-1:0]   r_op;
    logic [ZW-1:0]              r_size;
    logic [spa_pkg::SLOTF_W-1:0] r_slot;

    // repack walk and alloc decision
    logic [CW-1:0] r_idx;
    logic [OW-1:0] r_top;
    logic          r_fit;
    logic          r_found;
    logic [SW-1:0] r_pick;

    // result register
    logic                       r_ovalid;
    logic [spa_pkg::KIND_W-1:0] r_kind;
    logic [spa_pkg::SLOTF_W-1:0] r_onum;
    logic [OW-1:0]              r_ooff;
    logic [OW-1:0]              r_osrc;
    logic [OW-1:0]              r_olen;
    logic [ZW-1:0]              r_osize;
    logic                       r_ook;
    logic                       r_olast;

    // entry store: offset above, payload size below
    logic                         ram_we;
    logic [SW-1:0]                ram_waddr;
    logic [spa_pkg::ENTRY_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [SW-1:0]                ram_raddr;
    logic [spa_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [OW-1:0]                rd_off;
    logic [ZW-1:0]                rd_size;

    logic          out_free;
    logic          ld_result;
    logic          slot_live;
    logic [OW-1:0] mv_len;
    logic [OW-1:0] mv_top;
    logic [OW-1:0] new_top;
    logic [OW:0]   frag_sum;
    logic [OW+1:0] used_need;
    logic          enc_found;
    logic [SW-1:0] enc_pick;
    logic          full;

    // final result of init, free, get, defrag and unused opcodes
    logic [spa_pkg::KIND_W-1:0]  fin_kind;
    logic [spa_pkg::SLOTF_W-1:0] fin_num;
    logic [OW-1:0]               fin_off;
    logic [ZW-1:0]               fin_size;
    logic                        fin_ok;

    spa_ram #(
        .WIDTH (spa_pkg::ENTRY_W),
        .DEPTH (spa_pkg::MAX_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_off  = ram_rdata[spa_pkg::ENTRY_W-1:ZW];
    assign rd_size = ram_rdata[ZW-1:0];

    assign out_free  = !r_ovalid || !i_stall;
    assign ld_result = (i_cmd == spa_pkg::CMD_RP_MOVE) || (i_cmd == spa_pkg::CMD_ALLOC)
                       || (i_cmd == spa_pkg::CMD_FINAL);
    assign slot_live = ({1'b0, r_slot} < (spa_pkg::SLOTF_W+1)'(r_siu))
                       && r_valid[r_slot[SW-1:0]];
    assign full      = (r_siu >= CW'(spa_pkg::MAX_SLOTS));

    assign mv_len   = OW'(rd_size) + OW'(2);
    assign mv_top   = (r_top > mv_len) ? (r_top - mv_len) : '0;
    assign new_top  = r_free_top - (OW'(r_size) + OW'(2));
    assign frag_sum = (OW+1)'(r_frag) + (OW+1)'(rd_size) + (OW+1)'(2);
    assign used_need = (OW+2)'(spa_pkg::HEADER_BYTES) + ((OW+2)'(r_siu) << 1)
                       + (OW+2)'(r_frag) + (OW+2)'(r_size) + (OW+2)'(4);

    // highest free slot below the fill mark
    always_comb begin
        enc_found = 1'b0;
        enc_pick  = '0;
        for (int i = 0; i < spa_pkg::MAX_SLOTS; i++) begin
            if ((CW'(i) < r_siu) && !r_valid[i]) begin
                enc_found = 1'b1;
                enc_pick  = SW'(i);
            end
        end
    end

    always_comb begin
        fin_kind = spa_pkg::KIND_ACK;
        fin_num  = '0;
        fin_off  = '0;
        fin_size = '0;
        fin_ok   = 1'b0;
        case (r_op) inside
            spa_pkg::OP_INIT, spa_pkg::OP_DEFRAG: fin_ok = 1'b1;
            spa_pkg::OP_FREE: begin
                if (slot_live) begin
                    fin_num = r_slot;
                    fin_ok  = 1'b1;
                end
            end
            spa_pkg::OP_GET: begin
                fin_kind = spa_pkg::KIND_GET;
                if (slot_live) begin
                    fin_num  = r_slot;
                    fin_off  = rd_off;
                    fin_size = rd_size;
                    fin_ok   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[SW-1:0];
        ram_wdata = {mv_top, rd_size};
        ram_re    = 1'b0;
        ram_raddr = r_idx[SW-1:0];
        unique case (i_cmd)
            spa_pkg::CMD_DISPATCH: begin
                ram_re    = 1'b1;
                ram_raddr = r_slot[SW-1:0];
            end
            spa_pkg::CMD_RP_READ: ram_re = 1'b1;
            spa_pkg::CMD_RP_MOVE: ram_we = 1'b1;
            spa_pkg::CMD_ALLOC: begin
                ram_we    = r_fit && (r_found || !full);
                ram_waddr = r_found ? r_pick : r_siu[SW-1:0];
                ram_wdata = {new_top, r_size};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_siu      <= '0;
            r_frag     <= '0;
            r_free_top <= OW'(spa_pkg::PAGE_BYTES);
            r_ovalid   <= 1'b0;
        end else begin
            if (ld_result) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd)
                spa_pkg::CMD_RP_END: begin
                    r_free_top <= r_top;
                    r_frag     <= '0;
                end
                spa_pkg::CMD_ALLOC: begin
                    if (r_fit && (r_found || !full)) begin
                        r_free_top <= new_top;
                        if (r_found) begin
                            r_valid[r_pick] <= 1'b1;
                        end else begin
                            r_valid[r_siu[SW-1:0]] <= 1'b1;
                            r_siu <= r_siu + CW'(1);
                        end
                    end
                end
                spa_pkg::CMD_FINAL: begin
                    if (r_op == spa_pkg::OP_INIT) begin
                        r_valid    <= '0;
                        r_siu      <= '0;
                        r_frag     <= '0;
                        r_free_top <= OW'(spa_pkg::PAGE_BYTES);
                    end else if (r_op == spa_pkg::OP_FREE && slot_live) begin
                        r_valid[r_slot[SW-1:0]] <= 1'b0;
                        r_frag <= (frag_sum > (OW+1)'(spa_pkg::FRAG_MAX))
                                  ? OW'(spa_pkg::FRAG_MAX) : frag_sum[OW-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            spa_pkg::CMD_LATCH: begin
                r_op   <= i_opcode;
                r_size <= i_alloc_size;
                r_slot <= i_slot_index;
            end
            spa_pkg::CMD_DISPATCH: begin
                r_idx <= '0;
                r_top <= OW'(spa_pkg::PAGE_BYTES);
            end
            spa_pkg::CMD_RP_SKIP: r_idx <= r_idx + CW'(1);
            spa_pkg::CMD_RP_MOVE: begin
                r_idx   <= r_idx + CW'(1);
                r_top   <= mv_top;
                r_kind  <= spa_pkg::KIND_MOVE;
                r_onum  <= spa_pkg::SLOTF_W'(r_idx);
                r_ooff  <= mv_top;
                r_osrc  <= rd_off;
                r_olen  <= mv_len;
                r_osize <= '0;
                r_ook   <= 1'b1;
                r_olast <= 1'b0;
            end
            spa_pkg::CMD_SPACE: begin
                r_fit   <= ((OW+2)'(r_free_top) >= used_need);
                r_found <= enc_found;
                r_pick  <= enc_pick;
            end
            spa_pkg::CMD_ALLOC: begin
                r_kind  <= spa_pkg::KIND_ALLOC;
                r_osrc  <= '0;
                r_olen  <= '0;
                r_olast <= 1'b1;
                if (r_fit && (r_found || !full)) begin
                    r_onum  <= r_found ? spa_pkg::SLOTF_W'(r_pick)
                                       : spa_pkg::SLOTF_W'(r_siu);
                    r_ooff  <= new_top;
                    r_osize <= r_size;
                    r_ook   <= 1'b1;
                end else begin
                    r_onum  <= '0;
                    r_ooff  <= '0;
                    r_osize <= '0;
                    r_ook   <= 1'b0;
                end
            end
            spa_pkg::CMD_FINAL: begin
                r_kind  <= fin_kind;
                r_onum  <= fin_num;
                r_ooff  <= fin_off;
                r_osrc  <= '0;
                r_olen  <= '0;
                r_osize <= fin_size;
                r_ook   <= fin_ok;
                r_olast <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_status.op        = r_op;
    assign o_status.frag_high = (r_frag >= OW'(spa_pkg::FRAG_LIMIT));
    assign o_status.rp_done   = (r_idx >= r_siu);
    assign o_status.rp_live   = r_valid[r_idx[SW-1:0]];
    assign o_status.out_free  = out_free;

    assign o_valid         = r_ovalid;
    assign o_result_kind   = r_kind;
    assign o_slot_number   = r_onum;
    assign o_cell_offset   = r_ooff;
    assign o_source_offset = r_osrc;
    assign o_move_length   = r_olen;
    assign o_cell_size     = r_osize;
    assign o_ok            = r_ook;
    assign o_last          = r_olast;

    a_siu_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_siu <= CW'(spa_pkg::MAX_SLOTS))
        else $error("slot count past directory size");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= OW'(spa_pkg::PAGE_BYTES))
        else $error("free top beyond page end");

    a_rp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == spa_pkg::CMD_RP_END |=> r_frag == '0)
        else $error("fragment count not cleared by repack");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == spa_pkg::CMD_RP_MOVE || i_cmd == spa_pkg::CMD_ALLOC
         || i_cmd == spa_pkg::CMD_FINAL) |-> out_free)
        else $error("result loaded over a waiting result");

endmodule

/* design/slotted_page_allocator_unit.sv */
// Slot directory of one slotted page: cells grow down from the page end, the
// slot array grows up behind the header. Each transfer on the input channel
// carries one opcode (init, alloc, free, get, defrag) and yields one or more
// results, the final one flagged by o_last. Defrag, and an alloc that finds a
// quarter of the page fragmented, first walks the directory in slot order and
// emits one move command per live cell with old and new offsets; the page bytes
// themselves are copied elsewhere. Init, free, get and unused opcodes pass
// through dispatch and then load their final result; alloc passes through
// dispatch, the space check and the alloc decision; a repack adds a skip step
// per free slot and a read and a move step per live slot below the fill mark,
// plus an end step. The repack walk reads one directory entry per step from a
// single registered-read entry memory. One item is worked on at a time; the
// input stalls until its last result sits in the output register, and the
// next transfer can be taken as soon as it does.
module slotted_page_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [spa_pkg::OP_W-1:0]      i_opcode,
    input  logic [spa_pkg::SIZE_W-1:0]    i_alloc_size,
    input  logic [spa_pkg::SLOTF_W-1:0]   i_slot_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [spa_pkg::KIND_W-1:0]    o_result_kind,
    output logic [spa_pkg::SLOTF_W-1:0]   o_slot_number,
    output logic [spa_pkg::OFF_W-1:0]     o_cell_offset,
    output logic [spa_pkg::OFF_W-1:0]     o_source_offset,
    output logic [spa_pkg::OFF_W-1:0]     o_move_length,
    output logic [spa_pkg::SIZE_W-1:0]    o_cell_size,
    output logic                          o_ok,
    output logic                          o_last
);

    spa_pkg::t_cmd    cmd;
    spa_pkg::t_status status;
    logic             busy;

    // sequencing: dispatch, repack walk, alloc decision, result
    spa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // directory state, entry memory and output register
    spa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_alloc_size    (i_alloc_size),
        .i_slot_index    (i_slot_index),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_slot_number   (o_slot_number),
        .o_cell_offset   (o_cell_offset),
        .o_source_offset (o_source_offset),
        .o_move_length   (o_move_length),
        .o_cell_size     (o_cell_size),
        .o_ok            (o_ok),
        .o_last          (o_last)
    );

    // new transfers only while no item is in flight
    assign o_stall = busy;

endmodule

/* dv/slotted_page_allocator_checker.sv */
`timescale 1ns / 100ps

module slotted_page_allocator_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [spa_pkg::OP_W-1:0]      i_opcode,
    input  logic [spa_pkg::SIZE_W-1:0]    i_alloc_size,
    input  logic [spa_pkg::SLOTF_W-1:0]   i_slot_index,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [spa_pkg::KIND_W-1:0]    o_result_kind,
    input  logic [spa_pkg::SLOTF_W-1:0]   o_slot_number,
    input  logic [spa_pkg::OFF_W-1:0]     o_cell_offset,
    input  logic [spa_pkg::OFF_W-1:0]     o_source_offset,
    input  logic [spa_pkg::OFF_W-1:0]     o_move_length,
    input  logic [spa_pkg::SIZE_W-1:0]    o_cell_size,
    input  logic                          o_ok,
    input  logic                          o_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results_seen,
    output int                            o_moves_seen
);
    import spa_pkg::*;

    typedef struct {
        t_kind                kind;
        logic [SLOTF_W-1:0]   slot;
        logic [OFF_W-1:0]     off;
        logic [OFF_W-1:0]     src;
        logic [OFF_W-1:0]     len;
        logic [SIZE_W-1:0]    size;
        logic                 ok;
        logic                 last;
    } t_page_result;

    t_page_result expected_results[$];

    // shadow directory
    bit dir_live[MAX_SLOTS];
    int dir_off[MAX_SLOTS];
    int dir_size[MAX_SLOTS];
    int fill_mark;
    int dead_bytes;
    int cell_top;

    initial begin
        o_fail_count   = 0;
        o_results_seen = 0;
        o_moves_seen   = 0;
    end

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic void push_result(t_kind kind, int slot, int off, int src, int len,
                                        int size, bit ok);
        t_page_result r;
        r.kind = kind;
        r.slot = slot[SLOTF_W-1:0];
        r.off  = off[OFF_W-1:0];
        r.src  = src[OFF_W-1:0];
        r.len  = len[OFF_W-1:0];
        r.size = size[SIZE_W-1:0];
        r.ok   = ok;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void clear_directory();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            dir_live[i] = 1'b0;
            dir_off[i]  = 0;
            dir_size[i] = 0;
        end
        fill_mark  = 0;
        dead_bytes = 0;
        cell_top   = PAGE_BYTES;
    endfunction

    function automatic int free_space();
        int used;
        used = HEADER_BYTES + 2 * fill_mark + dead_bytes;
        return (cell_top > used) ? cell_top - used : 0;
    endfunction

    function automatic void repack_cells();
        int top;
        int len;
        top = PAGE_BYTES;
        dead_bytes = 0;
        for (int i = 0; i < fill_mark && i < MAX_SLOTS; i++) begin
            if (dir_live[i]) begin
                len = dir_size[i] + 2;
                top = (top > len) ? top - len : 0;
                push_result(KIND_MOVE, i, top, dir_off[i], len, 0, 1'b1);
                dir_off[i] = top;
            end
        end
        cell_top = top;
    endfunction

    function automatic void predict_item(logic [OP_W-1:0] op, logic [SIZE_W-1:0] sz,
                                         logic [SLOTF_W-1:0] idx);
        int  size;
        int  slot;
        int  pick;
        bit  found;
        bit  hit;
        int  f;
        size = sz;
        slot = idx;
        hit  = (slot < fill_mark) && (slot < MAX_SLOTS) && dir_live[slot % MAX_SLOTS];
        case (op)
            OP_INIT: begin
                clear_directory();
                push_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b1);
            end
            OP_ALLOC: begin
                pick  = 0;
                found = 1'b0;
                if (dead_bytes >= FRAG_LIMIT) repack_cells();
                if (free_space() < size + 4) begin
                    push_result(KIND_ALLOC, 0, 0, 0, 0, 0, 1'b0);
                end else begin
                    for (int i = 0; i < fill_mark && i < MAX_SLOTS; i++)
                        if (!dir_live[i]) begin
                            pick  = i;
                            found = 1'b1;
                        end
                    if (!found && fill_mark >= MAX_SLOTS) begin
                        // directory full
                        push_result(KIND_ALLOC, 0, 0, 0, 0, 0, 1'b0);
                    end else begin
                        if (!found) pick = fill_mark++;
                        cell_top       -= size + 2;
                        dir_live[pick]  = 1'b1;
                        dir_off[pick]   = cell_top;
                        dir_size[pick]  = size;
                        push_result(KIND_ALLOC, pick, cell_top, 0, 0, size, 1'b1);
                    end
                end
            end
            OP_FREE: begin
                if (hit) begin
                    f = dead_bytes + dir_size[slot] + 2;
                    dead_bytes = (f > FRAG_MAX) ? FRAG_MAX : f;
                    dir_live[slot] = 1'b0;
                    push_result(KIND_ACK, slot, 0, 0, 0, 0, 1'b1);
                end else begin
                    push_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b0);
                end
            end
            OP_GET: begin
                if (hit) push_result(KIND_GET, slot, dir_off[slot], 0, 0, dir_size[slot], 1'b1);
                else     push_result(KIND_GET, 0, 0, 0, 0, 0, 1'b0);
            end
            OP_DEFRAG: begin
                repack_cells();
                push_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b1);
            end
            default: push_result(KIND_ACK, 0, 0, 0, 0, 0, 1'b0);
        endcase
        expected_results[$].last = 1'b1;
    endfunction

    initial clear_directory();

    always @(posedge i_clk) begin
        t_page_result e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                o_results_seen++;
                if (o_result_kind == KIND_MOVE) o_moves_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_kind !== e.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", o_result_kind, e.kind));
                    if (o_slot_number !== e.slot)
                        report_mismatch($sformatf("slot %0d, want %0d", o_slot_number, e.slot));
                    if (o_cell_offset !== e.off)
                        report_mismatch($sformatf("offset %0d, want %0d", o_cell_offset, e.off));
                    if (o_source_offset !== e.src)
                        report_mismatch($sformatf("source %0d, want %0d", o_source_offset, e.src));
                    if (o_move_length !== e.len)
                        report_mismatch($sformatf("length %0d, want %0d", o_move_length, e.len));
                    if (o_cell_size !== e.size)
                        report_mismatch($sformatf("size %0d, want %0d", o_cell_size, e.size));
                    if (o_ok !== e.ok)
                        report_mismatch($sformatf("ok %0b, want %0b", o_ok, e.ok));
                    if (o_last !== e.last)
                        report_mismatch($sformatf("last %0b, want %0b", o_last, e.last));
                end
            end
            if (i_valid && !o_stall) predict_item(i_opcode, i_alloc_size, i_slot_index);
        end
    end

endmodule

/* dv/tb_slotted_page_allocator_unit.sv */
`timescale 1ns / 100ps

module tb_slotted_page_allocator_unit;
    import spa_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    // cycles without any transfer before the run is declared hung; a full
    // repack behind heavy output stalls stays well under this
    localparam int HANG_LIMIT   = 6000;
    localparam int DRAIN_CYCLES = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [OP_W-1:0]       i_opcode = '0;
    logic [SIZE_W-1:0]     i_alloc_size = '0;
    logic [SLOTF_W-1:0]    i_slot_index = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [KIND_W-1:0]     o_result_kind;
    logic [SLOTF_W-1:0]    o_slot_number;
    logic [OFF_W-1:0]      o_cell_offset;
    logic [OFF_W-1:0]      o_source_offset;
    logic [OFF_W-1:0]      o_move_length;
    logic [SIZE_W-1:0]     o_cell_size;
    logic                  o_ok;
    logic                  o_last;

    int fail_count;
    int pending;
    int results_seen;
    int moves_seen;
    int items_sent = 0;
    int tx_idle_pct = 0;    // sender gap probability, percent
    int rx_idle_pct = 0;    // receiver stall probability, percent
    int quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    slotted_page_allocator_unit dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_alloc_size, .i_slot_index,
        .o_valid, .i_stall, .o_result_kind, .o_slot_number, .o_cell_offset,
        .o_source_offset, .o_move_length, .o_cell_size, .o_ok, .o_last
    );

    slotted_page_allocator_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_alloc_size, .i_slot_index,
        .o_valid, .i_stall, .o_result_kind, .o_slot_number, .o_cell_offset,
        .o_source_offset, .o_move_length, .o_cell_size, .o_ok, .o_last,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results_seen(results_seen), .o_moves_seen(moves_seen)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // hang watchdog: any transfer on either channel resets the count
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", HANG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input transfer, with random gaps ahead of it
    task automatic send_item(input logic [OP_W-1:0] op, input int size, input int slot);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_alloc_size <= size[SIZE_W-1:0];
        i_slot_index <= slot[SLOTF_W-1:0];
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // hold off until every expected result is back, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int pick;
        int size;
        int slot;
        pick = $urandom_range(0, 99);
        // mostly small cells and slot indexes near the fill mark
        case ($urandom_range(0, 9))
            0:       size = $urandom_range(0, 4095);
            1, 2:    size = $urandom_range(0, 600);
            default: size = $urandom_range(0, 120);
        endcase
        slot = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 33);
        if (pick < 45)      send_item(OP_ALLOC, size, slot);
        else if (pick < 75) send_item(OP_FREE, size, slot);
        else if (pick < 90) send_item(OP_GET, size, slot);
        else if (pick < 95) send_item(OP_DEFRAG, size, slot);
        else if (pick < 97) send_item(OP_INIT, size, slot);
        else                send_item(3'($urandom_range(5, 7)), size, slot);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, each opcode, repair and failure cases
        send_item(OP_ALLOC, 0, 0);
        send_item(OP_ALLOC, 4095, 63);       // no space
        send_item(OP_ALLOC, 100, 0);
        send_item(OP_GET, 0, 1);
        send_item(OP_GET, 0, 63);            // beyond fill mark
        send_item(OP_FREE, 0, 63);
        send_item(OP_FREE, 0, 0);
        send_item(OP_FREE, 0, 0);            // already free, repaired into no-op
        send_item(OP_GET, 0, 0);
        send_item(OP_ALLOC, 50, 0);          // reuses the free slot
        send_item(OP_ALLOC, 1200, 0);
        send_item(OP_FREE, 0, 2);            // pushes fragments past a quarter page
        send_item(OP_ALLOC, 10, 0);          // repack runs first
        send_item(OP_DEFRAG, 0, 0);
        send_item(3'd5, 4095, 63);
        send_item(3'd6, 0, 0);
        send_item(3'd7, 0, 0);
        send_item(OP_INIT, 0, 0);
        for (int i = 0; i < MAX_SLOTS + 1; i++) send_item(OP_ALLOC, 0, 0);  // until full
        send_item(OP_GET, 0, MAX_SLOTS - 1);
        send_item(OP_DEFRAG, 0, 0);
        send_item(OP_INIT, 0, 0);
        wait_drained();

        // random, in three idling phases
        tx_idle_pct = 15;
        rx_idle_pct = 47;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                wait_drained();
                tx_idle_pct = 47;
                rx_idle_pct = 15;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_item();
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input items, %0d results checked (%0d cell moves)",
                 items_sent, results_seen, moves_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
